// ----- design/lfbrq_pkg.sv -----
// Shared constants, op codes and controller/datapath interface structs
// for the line framed byte ring queue. No dependencies.
package lfbrq_pkg;

    localparam int MAX_LINES  = 8;
    localparam int LINE_BYTES = 64;

    localparam int POS_W   = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int LINE_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int ADDR_W  = LINE_W + POS_W;
    localparam int PEND_W  = $clog2(MAX_LINES + 1);

    // configuration register widths
    localparam int SIZE_W  = 7;
    localparam int COUNT_W = 4;

    // working widths for the clamped register values
    localparam int SZ_W = (POS_W + 1 > SIZE_W) ? POS_W + 1 : SIZE_W;
    localparam int CT_W = (LINE_W + 1 > COUNT_W) ? LINE_W + 1 : COUNT_W;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(64);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // register index taken from the word address bit
    localparam logic REG_LINE_SIZE  = 1'b0;
    localparam logic REG_LINE_COUNT = 1'b1;

    typedef struct packed {
        logic accept;    // latch op and byte
        logic exec;      // run enqueue, status or empty dequeue, report
        logic rd_issue;  // read store at the read pointer
        logic rd_done;   // finish dequeue with the read byte, report
    } t_cmd;

    typedef struct packed {
        logic deq_go;    // latched op is a dequeue and a line is pending
    } t_sts;

endpackage

// ----- design/lfbrq_ctrl.sv -----
// Sequencer of the line framed byte ring queue: accepts a command beat and
// steps the datapath through execute and store read. Uses lfbrq_pkg.
module lfbrq_ctrl import lfbrq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.deq_go) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = S_READ;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_done = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/lfbrq_dp.sv -----
// Datapath of the line framed byte ring queue: line store, ring pointers,
// pending line count and result registers. Uses lfbrq_pkg.
module lfbrq_dp import lfbrq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [1:0]         i_op,
    input  logic [7:0]         i_data_in,
    input  logic [SIZE_W-1:0]  i_line_size,
    input  logic [COUNT_W-1:0] i_line_count,
    output logic [7:0]         o_data_out,
    output logic               o_out_valid,
    output logic               o_line_end,
    output logic               o_dropped,
    output logic               o_line_ready,
    output logic               o_done
);

    logic [7:0]        r_mem [2**ADDR_W];
    logic [7:0]        r_rd_data;

    logic [1:0]        r_op;
    logic [7:0]        r_din;
    logic [LINE_W-1:0] r_wline, n_wline, r_rline, n_rline;
    logic [POS_W-1:0]  r_wpos, n_wpos, r_rpos, n_rpos;
    logic [PEND_W-1:0] r_pending, n_pending;

    logic [7:0]        r_data_out, n_dout;
    logic              r_out_valid, n_valid;
    logic              r_line_end, n_end;
    logic              r_dropped, n_drop;
    logic              r_line_ready;
    logic              r_done;

    logic [SZ_W-1:0]   sz_raw, eff_size, last_pos;
    logic [CT_W-1:0]   ct_raw, eff_count;
    logic              full;
    logic              mem_we;
    logic              finish;

    function automatic logic f_closes(input logic [POS_W-1:0] pos,
                                      input logic [7:0] b,
                                      input logic [SZ_W-1:0] last);
        return (SZ_W'(pos) >= last) || (b == CH_NEWLINE) || (b == CH_NUL);
    endfunction

    function automatic logic [LINE_W-1:0] f_next(input logic [LINE_W-1:0] l,
                                                 input logic [CT_W-1:0] cnt);
        logic [CT_W-1:0] inc;
        inc = CT_W'(l) + CT_W'(1);
        return (inc >= cnt) ? '0 : inc[LINE_W-1:0];
    endfunction

    // clamp registers to their usable ranges
    assign sz_raw    = SZ_W'(i_line_size);
    assign eff_size  = (sz_raw == '0) ? SZ_W'(1) :
                       (sz_raw > SZ_W'(LINE_BYTES)) ? SZ_W'(LINE_BYTES) : sz_raw;
    assign last_pos  = eff_size - SZ_W'(1);
    assign ct_raw    = CT_W'(i_line_count);
    assign eff_count = (ct_raw == '0) ? CT_W'(1) :
                       (ct_raw > CT_W'(MAX_LINES)) ? CT_W'(MAX_LINES) : ct_raw;

    assign full         = CT_W'(r_pending) >= eff_count;
    assign o_sts.deq_go = (r_op == OP_DEQ) && (r_pending != '0);
    assign finish       = i_cmd.exec | i_cmd.rd_done;

    always_comb begin
        n_wline   = r_wline;
        n_wpos    = r_wpos;
        n_rline   = r_rline;
        n_rpos    = r_rpos;
        n_pending = r_pending;
        n_dout    = '0;
        n_valid   = 1'b0;
        n_end     = 1'b0;
        n_drop    = 1'b0;
        mem_we    = 1'b0;
        if (i_cmd.exec && (r_op == OP_ENQ)) begin
            if (full) begin
                n_drop = 1'b1;
            end else begin
                mem_we = 1'b1;
                if (f_closes(r_wpos, r_din, last_pos)) begin
                    n_wline   = f_next(r_wline, eff_count);
                    n_wpos    = '0;
                    n_pending = r_pending + PEND_W'(1);
                end else begin
                    n_wpos = r_wpos + POS_W'(1);
                end
            end
        end
        if (i_cmd.rd_done) begin
            n_dout  = r_rd_data;
            n_valid = 1'b1;
            if (f_closes(r_rpos, r_rd_data, last_pos)) begin
                n_end     = 1'b1;
                n_rline   = f_next(r_rline, eff_count);
                n_rpos    = '0;
                n_pending = r_pending - PEND_W'(1);
            end else begin
                n_rpos = r_rpos + POS_W'(1);
            end
        end
    end

    // line store: one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{r_wline, r_wpos}] <= r_din;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[{r_rline, r_rpos}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_din <= i_data_in;
        end
        if (finish) begin
            r_data_out <= n_dout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wline      <= '0;
            r_wpos       <= '0;
            r_rline      <= '0;
            r_rpos       <= '0;
            r_pending    <= '0;
            r_out_valid  <= 1'b0;
            r_line_end   <= 1'b0;
            r_dropped    <= 1'b0;
            r_line_ready <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_wline   <= n_wline;
            r_wpos    <= n_wpos;
            r_rline   <= n_rline;
            r_rpos    <= n_rpos;
            r_pending <= n_pending;
            r_done    <= finish;
            if (finish) begin
                r_out_valid  <= n_valid;
                r_line_end   <= n_end;
                r_dropped    <= n_drop;
                r_line_ready <= (n_pending != '0);
            end else begin
                r_out_valid <= 1'b0;
                r_line_end  <= 1'b0;
                r_dropped   <= 1'b0;
            end
        end
    end

    assign o_data_out   = r_data_out;
    assign o_out_valid  = r_out_valid;
    assign o_line_end   = r_line_end;
    assign o_dropped    = r_dropped;
    assign o_line_ready = r_line_ready;
    assign o_done       = r_done;

endmodule

// ----- design/line_framed_byte_ring_queue.sv -----
// Top level of the line framed byte ring queue: configuration registers on
// the APB-style port, sequencer and datapath. Uses lfbrq_pkg, lfbrq_ctrl, lfbrq_dp.
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+--------------------------------------
//  command   | i_start high, o_busy low        | i_op, i_data_in
//  result    | o_done strobe, one cycle        | o_data_out, o_out_valid, o_line_end,
//            |                                 | o_dropped, o_line_ready
//  config    | psel, penable, pwrite, pready   | paddr, pwdata (prdata on read)
//
// An enqueue, status or empty dequeue beat goes through the execute state before
// its result strobe; a dequeue that finds a pending line also goes through the
// read state, for the registered read of the line store. o_busy drops in the
// cycle of the strobe, so a new beat may be accepted then, and not before.
// Reset (synchronous, active low) clears the pointers, the pending count and
// the registers; the line store is not cleared and needs no sweep.
// Results cannot be held off by the receiver; each is shown for one cycle.
module line_framed_byte_ring_queue import lfbrq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command beat
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_in,
    // result beat
    output logic        o_done,
    output logic [7:0]  o_data_out,
    output logic        o_out_valid,
    output logic        o_line_end,
    output logic        o_dropped,
    output logic        o_line_ready,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SIZE_W-1:0]  r_line_size;
    logic [COUNT_W-1:0] r_line_count;
    logic               cfg_wr;
    logic               reg_sel;
    t_cmd               cmd;
    t_sts               sts;

    // Register decode uses the word address bit only; byte offsets alias.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_size  <= SIZE_RESET;
            r_line_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_LINE_SIZE:  r_line_size  <= pwdata[SIZE_W-1:0];
                REG_LINE_COUNT: r_line_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LINE_SIZE:  prdata = 32'(r_line_size);
            REG_LINE_COUNT: prdata = 32'(r_line_count);
            default:        prdata = '0;
        endcase
    end

    lfbrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    lfbrq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_data_in    (i_data_in),
        .i_line_size  (r_line_size),
        .i_line_count (r_line_count),
        .o_data_out   (o_data_out),
        .o_out_valid  (o_out_valid),
        .o_line_end   (o_line_end),
        .o_dropped    (o_dropped),
        .o_line_ready (o_line_ready),
        .o_done       (o_done)
    );

    // an accepted beat keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not raise busy");

    // every result strobe closes a busy period
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without work in flight");

    // flags appear only with the strobe, and a line end only with a byte
    a_flags_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid || o_dropped) |-> o_done)
        else $error("result flag outside a result beat");

    a_end_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_line_end |-> (o_out_valid && !o_dropped))
        else $error("line end without a dequeued byte");

endmodule

// ----- dv/tb_line_framed_byte_ring_queue.sv -----
`timescale 1ns / 100ps
// Self-checking bench for line_framed_byte_ring_queue: a beat-level model of the line ring
// predicts every result beat, which a monitor compares field by field.
// Depends on lfbrq_pkg and the block's RTL.
module tb_line_framed_byte_ring_queue;
    import lfbrq_pkg::*;

    // op codes the package leaves unnamed
    localparam logic [1:0] OP_STATUS = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;   // unused code, answers like a status query

    // register map: one 32-bit word per register
    localparam logic [2:0] ADDR_LINE_SIZE  = 3'd0;
    localparam logic [2:0] ADDR_LINE_COUNT = 3'd4;

    localparam int MAX_GAP         = 13;
    localparam int STALL_LIMIT     = 500;
    localparam int PHASES          = 10;
    localparam int BEATS_PER_PHASE = 100;
    localparam int STORE_BYTES     = MAX_LINES * LINE_BYTES;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       eol;
        logic       drop;
        logic       ready;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_start   = 1'b0;
    logic [1:0]  i_op      = OP_STATUS;
    logic [7:0]  i_data_in = 8'h00;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = ADDR_LINE_SIZE;
    logic [31:0] pwdata    = '0;

    logic        o_busy;
    logic        o_done;
    logic [7:0]  o_data_out;
    logic        o_out_valid;
    logic        o_line_end;
    logic        o_dropped;
    logic        o_line_ready;
    logic [31:0] prdata;
    logic        pready;

    // model of the ring: byte store, pointers, pending line count, registers
    logic [7:0]         ring_bytes [STORE_BYTES];
    int unsigned        wr_line, wr_pos, rd_line, rd_pos, lines_waiting;
    logic [SIZE_W-1:0]  size_reg  = SIZE_RESET;
    logic [COUNT_W-1:0] count_reg = COUNT_RESET;

    t_reply replies_due [$];
    int     mismatch_count = 0;
    int     idle_cycles    = 0;
    bit     no_gaps        = 1'b0;

    line_framed_byte_ring_queue u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_op         (i_op),
        .i_data_in    (i_data_in),
        .o_done       (o_done),
        .o_data_out   (o_data_out),
        .o_out_valid  (o_out_valid),
        .o_line_end   (o_line_end),
        .o_dropped    (o_dropped),
        .o_line_ready (o_line_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Ring model
    // ------------------------------------------------------------------

    // slot size and slot count in use: registers clamped to what the ring holds
    function automatic int unsigned slot_bytes();
        if (size_reg == 0) return 1;
        if (size_reg > LINE_BYTES) return LINE_BYTES;
        return size_reg;
    endfunction

    function automatic int unsigned slot_total();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_LINES) return MAX_LINES;
        return count_reg;
    endfunction

    // a line closes on newline, on NUL, or at (or past) the last position in use
    function automatic bit ends_line(int unsigned pos, logic [7:0] b);
        return (pos + 1 >= slot_bytes()) || b == CH_NEWLINE || b == CH_NUL;
    endfunction

    function automatic int unsigned following_line(int unsigned line);
        return (line + 1 >= slot_total()) ? 0 : line + 1;
    endfunction

    function automatic int unsigned byte_index(int unsigned line, int unsigned pos);
        int unsigned idx;
        idx = line * LINE_BYTES + pos;
        return (idx < STORE_BYTES) ? idx : 0;
    endfunction

    // Apply one command beat to the model and return the result beat it causes.
    function automatic t_reply advance_ring(logic [1:0] op, logic [7:0] b);
        t_reply      r;
        logic [7:0]  got;
        r = '0;
        case (op)
            OP_ENQ: begin
                if (lines_waiting >= slot_total()) begin
                    r.drop = 1'b1;
                end else begin
                    ring_bytes[byte_index(wr_line, wr_pos)] = b;
                    if (ends_line(wr_pos, b)) begin
                        wr_line = following_line(wr_line);
                        wr_pos  = 0;
                        lines_waiting++;
                    end else begin
                        wr_pos++;
                    end
                end
            end
            OP_DEQ: begin
                if (lines_waiting != 0) begin
                    got     = ring_bytes[byte_index(rd_line, rd_pos)];
                    r.data  = got;
                    r.valid = 1'b1;
                    if (ends_line(rd_pos, got)) begin
                        r.eol   = 1'b1;
                        rd_line = following_line(rd_line);
                        rd_pos  = 0;
                        lines_waiting--;
                    end else begin
                        rd_pos++;
                    end
                end
            end
            default: begin
            end
        endcase
        r.ready = (lines_waiting != 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one command beat after a random gap. Start is left high after the
    // beat so back-to-back beats never lower and raise it in one step.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_op      <= op;
        i_data_in <= b;
        do @(posedge i_clk); while (o_busy);
        // accepted at this edge
        replies_due.push_back(advance_ring(op, b));
    endtask

    // Lower start, wait until every expected beat has come back, and let the
    // block go idle.
    task automatic settle();
        i_start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data at the
    // edge that ends the access cycle (pready is tied high).
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LINE_SIZE) size_reg = value[SIZE_W-1:0];
        else count_reg = value[COUNT_W-1:0];
    endtask

    // Read out every closed line, so no stale slot is ever read under new sizes.
    // A part-written line stays open across the change.
    task automatic drain_ring();
        while (lines_waiting != 0) send_beat(OP_DEQ, 8'($urandom));
    endtask

    // Drain, then write both registers; junk in the upper data bits must be ignored.
    task automatic configure(input int unsigned size, input int unsigned count);
        drain_ring();
        write_reg(ADDR_LINE_SIZE, {25'($urandom), 7'(size)});
        write_reg(ADDR_LINE_COUNT, {28'($urandom), 4'(count)});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Status, empty dequeue and the spare op straight out of reset.
    task automatic test_reset_state();
        send_beat(OP_STATUS, 8'hFF);
        send_beat(OP_DEQ, 8'h00);
        send_beat(OP_SPARE, 8'hA5);
    endtask

    // Close lines on NUL and on newline with the reset sizes, then read them back.
    task automatic test_line_framing();
        send_beat(OP_ENQ, 8'hFF);
        send_beat(OP_ENQ, CH_NUL);
        send_beat(OP_ENQ, CH_NEWLINE);
        send_beat(OP_STATUS, 8'h00);
        repeat (3) send_beat(OP_DEQ, 8'hFF);
        send_beat(OP_DEQ, 8'h00);
    endtask

    // Zero registers clamp to one slot of one byte: every byte closes a line,
    // so the second enqueue finds the ring full and is dropped.
    task automatic test_full_ring();
        configure(0, 0);
        send_beat(OP_ENQ, 8'h41);
        send_beat(OP_ENQ, 8'h42);
        send_beat(OP_DEQ, 8'h00);
        send_beat(OP_DEQ, 8'h00);
        send_beat(OP_STATUS, 8'h00);
    endtask

    // Oversized registers clamp to the full ring. Leave a part-written line in
    // slot 2, then shrink both registers: the write position is past the new
    // slot end, so the next byte closes the line, and the write line is past
    // the new slot count, so it wraps to slot 0.
    task automatic test_clamps_and_wrap();
        configure(127, 15);
        send_beat(OP_ENQ, CH_NEWLINE);
        send_beat(OP_ENQ, CH_NEWLINE);
        send_beat(OP_DEQ, 8'h00);
        send_beat(OP_DEQ, 8'h00);
        send_beat(OP_ENQ, 8'h80);
        send_beat(OP_ENQ, 8'h7F);
        send_beat(OP_ENQ, 8'h01);
        configure(2, 2);
        send_beat(OP_ENQ, 8'h55);
        repeat (3) send_beat(OP_DEQ, 8'h00);
    endtask

    // Phases of random traffic, each under its own register setting. Within a
    // phase, bias swings between filling and emptying the ring so that full
    // and empty rings both come up; gap-free stretches alternate with gaps.
    task automatic test_random_traffic();
        int unsigned sizes  [8] = '{64, 1, 64, 1, 2, 7, 100, 33};
        int unsigned counts [8] = '{8, 1, 1, 8, 3, 5, 12, 0};
        int unsigned term_one_in, pick, size, count;
        bit          fill_bias;
        logic [1:0]  op;
        logic [7:0]  b;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 8) begin
                size  = sizes[ph];
                count = counts[ph];
            end else begin
                size  = $urandom_range(0, 127);
                count = $urandom_range(0, 15);
            end
            configure(size, count);
            // terminator density: none at all lets long lines fill their slot
            case ($urandom_range(0, 3))
                0: term_one_in = 0;
                1: term_one_in = 4;
                2: term_one_in = 12;
                default: term_one_in = 40;
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n % 32 == 0) begin
                    fill_bias = 1'($urandom_range(0, 1));
                    no_gaps   = ($urandom_range(0, 2) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 6) op = $urandom_range(0, 1) ? OP_STATUS : OP_SPARE;
                else if (pick < (fill_bias ? 80 : 30)) op = OP_ENQ;
                else op = OP_DEQ;
                b = 8'($urandom);
                if (term_one_in != 0 && $urandom_range(1, term_one_in) == 1)
                    b = ($urandom_range(0, 3) == 0) ? CH_NUL : CH_NEWLINE;
                send_beat(op, b);
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_line_framing();
        test_full_ring();
        test_clamps_and_wrap();
        test_random_traffic();
        settle();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) $display("[line_framed_byte_ring_queue] OK");
        else $display("[line_framed_byte_ring_queue] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endfunction

    // Sample the pre-edge outputs; each strobed beat pairs with the oldest prediction.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_done) begin
            if (replies_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat expected none got data_out %0h", $time, o_data_out);
            end else begin
                want = replies_due.pop_front();
                check_field("data_out", want.data, o_data_out);
                check_field("out_valid", want.valid, o_out_valid);
                check_field("line_end", want.eol, o_line_end);
                check_field("dropped", want.drop, o_dropped);
                check_field("line_ready", want.ready, o_line_ready);
            end
        end
    end

    // Watchdog: end the run if no beat moves on any port for too long.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[line_framed_byte_ring_queue] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
